@@ rtl/pcs_pkg.sv @@
package pcs_pkg;

	// Widths of the input fields and of the internal arithmetic.
	localparam int unsigned PARENT_W = 20;
	localparam int unsigned PRIOR_W  = 16;
	localparam int unsigned VISITS_W = 20;
	localparam int unsigned TOTAL_W  = 29;
	localparam int unsigned LOSS_W   = 16;
	localparam int unsigned WEIGHT_W = 16;
	localparam int unsigned INDEX_W  = 8;
	localparam int unsigned ROOT_W   = 10;
	localparam int unsigned COMMON_W = WEIGHT_W + ROOT_W;
	localparam int unsigned SCORE_W  = 48;

	// Exploration numerator prior * explore_common, 42 bits.
	localparam int unsigned EXPN_W   = PRIOR_W + COMMON_W;
	// Exploration divisor (1 + visits) << 12, 33 bits.
	localparam int unsigned EXPD_W   = VISITS_W + 1 + 12;
	// Action magnitude |total + loss << 8| << 8, at most 38 bits.
	localparam int unsigned ACTN_W   = 38;

	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd4096;
	localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

endpackage

@@ rtl/puct_best_child_select.sv @@
// PUCT best-child selector. Children of one node stream in, one beat each;
// the beat with final_edge high closes the run and yields one result beat
// holding the position of the highest score (first of equals wins) and an
// overflow flag for runs longer than MAX_CHILDREN. The arithmetic is done
// bit-serially: the first beat of a run runs a restoring square root and
// then the weight multiply, then every child runs the prior multiply and
// two restoring dividers that share one step counter and produce both
// quotients in parallel, one quotient bit per cycle per quotient. A new
// beat is taken only when the last one is done; beats past MAX_CHILDREN
// skip the arithmetic. The result waits in an output register while the
// next run is taken in.
module puct_best_child_select #(
	parameter int unsigned MAX_CHILDREN = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pcs_pkg::WEIGHT_W-1:0]   cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [pcs_pkg::PARENT_W-1:0]   parent_visits,
	input  logic [pcs_pkg::PRIOR_W-1:0]    prior,
	input  logic [pcs_pkg::VISITS_W-1:0]   edge_visits,
	input  logic signed [pcs_pkg::TOTAL_W-1:0] value_total,
	input  logic [pcs_pkg::LOSS_W-1:0]     pending_loss,
	input  logic                           final_edge,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [pcs_pkg::INDEX_W-1:0]    chosen_index,
	output logic                           overflowed
);
	import pcs_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_CHILDREN + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SQRT, ST_WMUL, ST_PMUL, ST_DIV, ST_CMP, ST_DONE
	} state_t;

	state_t state_q;
	logic [5:0] step_q;

	// Latched beat.
	logic [PARENT_W-1:0] rad_q;
	logic [PRIOR_W-1:0] prior_q;
	logic [VISITS_W-1:0] visits_q;
	logic act_neg_q;
	logic last_q;

	// Run state.
	logic [WEIGHT_W-1:0] weight_q;
	logic [COMMON_W-1:0] common_q;
	logic signed [SCORE_W-1:0] best_q;
	logic [INDEX_W-1:0] best_pos_q;
	logic [CNT_W-1:0] count_q;
	logic run_q;
	logic ovf_q;

	// Square-root datapath.
	logic [ROOT_W-1:0] root_q;
	logic [ROOT_W+2:0] rem_q;

	// Serial multiplier: shift-add, one multiplier bit per cycle.
	logic [EXPN_W-1:0] acc_q;
	logic [EXPN_W-1:0] mcand_q;
	logic [PRIOR_W-1:0] mplier_q;

	// Two restoring dividers sharing one step counter.
	logic [EXPN_W-1:0] en_q;
	logic [EXPD_W:0] er_q;
	logic [ACTN_W-1:0] an_q;
	logic [VISITS_W:0] ar_q;
	logic [EXPD_W-1:0] ed_q;

	// Output register.
	logic out_valid_q;
	logic [INDEX_W-1:0] out_idx_q;
	logic out_ovf_q;

	logic overflow_item;
	logic signed [TOTAL_W+1:0] act_sum;
	logic [TOTAL_W:0] act_mag;
	logic [ROOT_W+2:0] sq_trial;
	logic [ROOT_W+2:0] sq_next;
	logic [EXPD_W:0] er_shift;
	logic [VISITS_W:0] ar_shift;
	logic signed [SCORE_W-1:0] score;
	logic signed [SCORE_W-1:0] explore_s;
	logic signed [SCORE_W-1:0] action_s;

	assign cfg_ready = (state_q == ST_IDLE);
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign chosen_index = out_idx_q;
	assign overflowed = out_ovf_q;

	assign overflow_item = run_q && (count_q >= CNT_W'(MAX_CHILDREN));

	// Signed action sum and its magnitude.
	assign act_sum = (TOTAL_W+2)'(value_total) +
		(TOTAL_W+2)'({pending_loss, 8'd0});
	assign act_mag = act_sum[TOTAL_W+1] ? (TOTAL_W+1)'(0) - act_sum[TOTAL_W:0]
		: act_sum[TOTAL_W:0];

	// Square root step: bring in two radicand bits, try 4*root+1.
	assign sq_next  = {rem_q[ROOT_W:0], rad_q[PARENT_W-1 -: 2]};
	assign sq_trial = {1'b0, root_q, 2'b01};

	// Divider shifts.
	assign er_shift = {er_q[EXPD_W-1:0], en_q[EXPN_W-1]};
	assign ar_shift = {ar_q[VISITS_W-1:0], an_q[ACTN_W-1]};

	// Score from the two quotients.
	assign explore_s = SCORE_W'(en_q);
	assign action_s  = (visits_q == '0) ? '0 :
		(act_neg_q ? SCORE_W'(an_q) : -SCORE_W'(an_q));
	assign score = explore_s + action_s;

	// Sequencer with its datapath and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			weight_q <= WEIGHT_RESET;
			common_q <= '0;
			best_q <= SCORE_MIN;
			best_pos_q <= '0;
			count_q <= '0;
			run_q <= 1'b0;
			ovf_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_idx_q <= '0;
			out_ovf_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready)
				weight_q <= cfg_data;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						rad_q <= parent_visits;
						prior_q <= prior;
						visits_q <= edge_visits;
						last_q <= final_edge;
						act_neg_q <= act_sum[TOTAL_W+1];
						an_q <= ACTN_W'({act_mag, 8'd0});
						root_q <= '0;
						rem_q <= '0;
						step_q <= '0;
						if (!run_q) begin
							best_q <= SCORE_MIN;
							best_pos_q <= '0;
							count_q <= '0;
							ovf_q <= 1'b0;
							run_q <= 1'b1;
							state_q <= ST_SQRT;
						end else if (overflow_item) begin
							ovf_q <= 1'b1;
							state_q <= ST_CMP;
						end else begin
							state_q <= ST_PMUL;
							acc_q <= '0;
							mcand_q <= EXPN_W'(common_q);
							mplier_q <= prior;
						end
					end
				end
				ST_SQRT: begin
					rad_q <= {rad_q[PARENT_W-3:0], 2'b00};
					if (sq_next >= sq_trial) begin
						rem_q <= sq_next - sq_trial;
						root_q <= {root_q[ROOT_W-2:0], 1'b1};
					end else begin
						rem_q <= sq_next;
						root_q <= {root_q[ROOT_W-2:0], 1'b0};
					end
					step_q <= step_q + 6'd1;
					if (step_q == 6'(ROOT_W - 1)) begin
						state_q <= ST_WMUL;
						step_q <= '0;
						acc_q <= '0;
						mplier_q <= weight_q;
					end
				end
				ST_WMUL: begin
					// weight times root, one weight bit per cycle.
					if (step_q == '0)
						mcand_q <= EXPN_W'(root_q);
					else begin
						if (mplier_q[0])
							acc_q <= acc_q + mcand_q;
						mcand_q <= {mcand_q[EXPN_W-2:0], 1'b0};
						mplier_q <= mplier_q >> 1;
					end
					step_q <= step_q + 6'd1;
					if (step_q == 6'(WEIGHT_W)) begin
						common_q <= COMMON_W'(acc_q + (mplier_q[0] ? mcand_q : '0));
						state_q <= ST_PMUL;
						step_q <= '0;
						acc_q <= '0;
						mcand_q <= EXPN_W'(COMMON_W'(acc_q +
							(mplier_q[0] ? mcand_q : '0)));
						mplier_q <= prior_q;
					end
				end
				ST_PMUL: begin
					if (mplier_q[0])
						acc_q <= acc_q + mcand_q;
					mcand_q <= {mcand_q[EXPN_W-2:0], 1'b0};
					mplier_q <= mplier_q >> 1;
					step_q <= step_q + 6'd1;
					if (step_q == 6'(PRIOR_W - 1)) begin
						en_q <= acc_q + (mplier_q[0] ? mcand_q : '0);
						er_q <= '0;
						ar_q <= '0;
						ed_q <= {EXPD_W'(visits_q) + EXPD_W'(1)} << 12;
						step_q <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					// Exploration quotient on every step.
					if (er_shift >= {1'b0, ed_q}) begin
						er_q <= er_shift - {1'b0, ed_q};
						en_q <= {en_q[EXPN_W-2:0], 1'b1};
					end else begin
						er_q <= er_shift;
						en_q <= {en_q[EXPN_W-2:0], 1'b0};
					end
					// Action quotient only on its last steps, from step EXPN_W - ACTN_W on.
					if (step_q >= 6'(EXPN_W - ACTN_W)) begin
						if (visits_q != '0 && ar_shift >= {1'b0, visits_q}) begin
							ar_q <= ar_shift - {1'b0, visits_q};
							an_q <= {an_q[ACTN_W-2:0], 1'b1};
						end else begin
							ar_q <= ar_shift;
							an_q <= {an_q[ACTN_W-2:0], 1'b0};
						end
					end
					step_q <= step_q + 6'd1;
					if (step_q == 6'(EXPN_W - 1))
						state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (!overflow_item) begin
						if (score > best_q) begin
							best_q <= score;
							best_pos_q <= INDEX_W'(count_q);
						end
						count_q <= count_q + CNT_W'(1);
					end
					state_q <= last_q ? ST_DONE : ST_IDLE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_idx_q <= best_pos_q;
						out_ovf_q <= ovf_q;
						run_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// A result never appears while a child is being scored.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the closing step");

	// The child count never passes the limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_CHILDREN))
		else $error("child count beyond limit");

	// A pending result is not overwritten before it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(out_idx_q))
		else $error("pending result lost");

endmodule
